/* rtl/detection_box_decode_top_macros.svh */
// Assertion macros shared by the RTL. All of them sample on clk_i and are
// disabled while rst_ni is low.
`ifndef DETECTION_BOX_DECODE_TOP_MACROS_SVH
`define DETECTION_BOX_DECODE_TOP_MACROS_SVH

// Same-cycle implication.
`define DBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dbd_pkg.sv */
package dbd_pkg;

  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned FRAME_W    = 13;
  localparam int unsigned NUM_SCORES = 5;
  localparam int unsigned FRAC_W     = 14;
  localparam int unsigned PROD_W     = COORD_W + FRAME_W + 1;
  localparam int unsigned EDGE_W     = 14;
  localparam int unsigned SIZE_W     = 15;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [CLASS_W-1:0] CLASS_COUNT_RST  = 3'd6;
  localparam logic [FRAME_W-1:0] FRAME_SIZE_RST   = 13'd1024;
  localparam logic [SCORE_W-1:0] THRESHOLD_RST    = 16'd0;

  typedef enum logic [2:0] {
    REG_CLASS_COUNT     = 3'd0,
    REG_FRAME_WIDTH     = 3'd1,
    REG_FRAME_HEIGHT    = 3'd2,
    REG_THRESHOLD_ONE   = 3'd3,
    REG_THRESHOLD_TWO   = 3'd4,
    REG_THRESHOLD_THREE = 3'd5,
    REG_THRESHOLD_FOUR  = 3'd6,
    REG_THRESHOLD_FIVE  = 3'd7
  } cfg_reg_e;

  // What one class lane reports to the merge stage.
  typedef struct packed {
    logic               qual;
    logic [SCORE_W-1:0] score;
  } lane_t;

endpackage

/* rtl/dbd_lane.sv */
module dbd_lane import dbd_pkg::*; #(
  parameter int unsigned LANE_ID = 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [CLASS_W-1:0] limit_i,
  input  logic [SCORE_W-1:0] score_i,
  input  logic [SCORE_W-1:0] thresh_i,
  output lane_t              res_o
);

  lane_t res_d, res_q;

  always_comb begin
    res_d.qual  = (CLASS_W'(LANE_ID) < limit_i) && (score_i >= thresh_i);
    res_d.score = score_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/dbd_merge.sv */
module dbd_merge import dbd_pkg::*; #(
  parameter int unsigned NUM_LANES = 5
) (
  input  lane_t              lanes_i [NUM_LANES],
  output logic               found_o,
  output logic [CLASS_W-1:0] class_id_o,
  output logic [SCORE_W-1:0] confidence_o
);

  // Ascending scan with strict compare: a tie keeps the lower class.
  always_comb begin
    found_o      = 1'b0;
    class_id_o   = '0;
    confidence_o = '0;
    for (int unsigned i = 0; i < NUM_LANES; i++) begin
      if (lanes_i[i].qual && (!found_o || lanes_i[i].score > confidence_o)) begin
        found_o      = 1'b1;
        class_id_o   = CLASS_W'(i + 1);
        confidence_o = lanes_i[i].score;
      end
    end
  end

endmodule

/* rtl/dbd_box_scale.sv */
module dbd_box_scale import dbd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] x_low_i,
  input  logic signed [COORD_W-1:0] y_low_i,
  input  logic signed [COORD_W-1:0] x_high_i,
  input  logic signed [COORD_W-1:0] y_high_i,
  input  logic        [FRAME_W-1:0] frame_width_i,
  input  logic        [FRAME_W-1:0] frame_height_i,
  output logic signed [EDGE_W-1:0]  box_left_o,
  output logic signed [EDGE_W-1:0]  box_top_o,
  output logic signed [SIZE_W-1:0]  box_width_o,
  output logic signed [SIZE_W-1:0]  box_height_o
);

  localparam int unsigned EDGE_SH_W = PROD_W - FRAC_W;
  localparam int unsigned SIZE_SH_W = PROD_W + 1 - FRAC_W;

  localparam logic signed [EDGE_SH_W-1:0] EDGE_MAX = EDGE_SH_W'((1 << (EDGE_W - 1)) - 1);
  localparam logic signed [EDGE_SH_W-1:0] EDGE_MIN = -EDGE_MAX - EDGE_SH_W'(1);
  localparam logic signed [SIZE_SH_W-1:0] SIZE_MAX = SIZE_SH_W'((1 << (SIZE_W - 1)) - 1);
  localparam logic signed [SIZE_SH_W-1:0] SIZE_MIN = -SIZE_MAX - SIZE_SH_W'(1);

  function automatic logic [EDGE_W-1:0] sat_edge(logic signed [EDGE_SH_W-1:0] v);
    logic [EDGE_W-1:0] r;
    if (v > EDGE_MAX) begin
      r = EDGE_MAX[EDGE_W-1:0];
    end else if (v < EDGE_MIN) begin
      r = EDGE_MIN[EDGE_W-1:0];
    end else begin
      r = v[EDGE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] sat_size(logic signed [SIZE_SH_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v > SIZE_MAX) begin
      r = SIZE_MAX[SIZE_W-1:0];
    end else if (v < SIZE_MIN) begin
      r = SIZE_MIN[SIZE_W-1:0];
    end else begin
      r = v[SIZE_W-1:0];
    end
    return r;
  endfunction

  logic signed [PROD_W-1:0] pxl_d, pyl_d, pxh_d, pyh_d;
  logic signed [PROD_W-1:0] pxl_q, pyl_q, pxh_q, pyh_q;
  logic signed [PROD_W:0]   dx, dy;

  // Frame sizes are unsigned; a zero sign bit makes them signed operands.
  always_comb begin
    pxl_d = PROD_W'(x_low_i  * $signed({1'b0, frame_width_i}));
    pxh_d = PROD_W'(x_high_i * $signed({1'b0, frame_width_i}));
    pyl_d = PROD_W'(y_low_i  * $signed({1'b0, frame_height_i}));
    pyh_d = PROD_W'(y_high_i * $signed({1'b0, frame_height_i}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxl_q <= pxl_d;
      pyl_q <= pyl_d;
      pxh_q <= pxh_d;
      pyh_q <= pyh_d;
    end
  end

  // Arithmetic shift right floors toward minus infinity.
  always_comb begin
    dx = (PROD_W+1)'(pxh_q) - (PROD_W+1)'(pxl_q);
    dy = (PROD_W+1)'(pyh_q) - (PROD_W+1)'(pyl_q);
    box_left_o   = sat_edge(pxl_q[PROD_W-1:FRAC_W]);
    box_top_o    = sat_edge(pyl_q[PROD_W-1:FRAC_W]);
    box_width_o  = sat_size(dx[PROD_W:FRAC_W]);
    box_height_o = sat_size(dy[PROD_W:FRAC_W]);
  end

endmodule

/* rtl/detection_box_decode_top.sv */
// Detection box decode: picks the best qualifying class of one detector box
// and scales its normalized corners to pixels.
// Input channel: one box per word (in_valid_i/in_ready_o), four Q2.14
// corners and five Q0.16 class scores. Output channel (out_valid_o/
// out_ready_i): class, score and pixel box. A box with no class at or above
// its threshold, below the class count, produces no output word.
// Throughput is one box per cycle while out_ready_i is high. Stage one holds
// the per-class threshold lanes and the four coordinate multipliers; stage
// two merges the lanes, takes the box differences and saturates into the
// output register. When the receiver stalls, the output word holds and
// stage one still takes one more box; in_ready_o drops only once both
// stages are full. Configuration goes through the APB port, registers at
// byte offsets 4*i; the user must write them only while no box is in
// flight, which the block does not enforce. Reset clears the pipeline
// valids and loads class_count 6, frame sizes 1024 and all thresholds 0.
`include "detection_box_decode_top_macros.svh"

module detection_box_decode_top import dbd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] x_low_i,
  input  logic signed [COORD_W-1:0] y_low_i,
  input  logic signed [COORD_W-1:0] x_high_i,
  input  logic signed [COORD_W-1:0] y_high_i,
  input  logic [SCORE_W-1:0]        score_one_i,
  input  logic [SCORE_W-1:0]        score_two_i,
  input  logic [SCORE_W-1:0]        score_three_i,
  input  logic [SCORE_W-1:0]        score_four_i,
  input  logic [SCORE_W-1:0]        score_five_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CLASS_W-1:0]        class_id_o,
  output logic [SCORE_W-1:0]        confidence_o,
  output logic signed [EDGE_W-1:0]  box_left_o,
  output logic signed [EDGE_W-1:0]  box_top_o,
  output logic signed [SIZE_W-1:0]  box_width_o,
  output logic signed [SIZE_W-1:0]  box_height_o
);

  localparam int unsigned NUM_LANES = MAX_CLASSES - 1;

  // ---------------- configuration ----------------
  logic [CLASS_W-1:0] class_count_q;
  logic [FRAME_W-1:0] frame_width_q, frame_height_q;
  logic [SCORE_W-1:0] thresh_q [NUM_SCORES];
  logic               cfg_we;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q  <= CLASS_COUNT_RST;
      frame_width_q  <= FRAME_SIZE_RST;
      frame_height_q <= FRAME_SIZE_RST;
      for (int unsigned i = 0; i < NUM_SCORES; i++) begin
        thresh_q[i] <= THRESHOLD_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_CLASS_COUNT:     class_count_q  <= pwdata[CLASS_W-1:0];
        REG_FRAME_WIDTH:     frame_width_q  <= pwdata[FRAME_W-1:0];
        REG_FRAME_HEIGHT:    frame_height_q <= pwdata[FRAME_W-1:0];
        REG_THRESHOLD_ONE:   thresh_q[0]    <= pwdata[SCORE_W-1:0];
        REG_THRESHOLD_TWO:   thresh_q[1]    <= pwdata[SCORE_W-1:0];
        REG_THRESHOLD_THREE: thresh_q[2]    <= pwdata[SCORE_W-1:0];
        REG_THRESHOLD_FOUR:  thresh_q[3]    <= pwdata[SCORE_W-1:0];
        REG_THRESHOLD_FIVE:  thresh_q[4]    <= pwdata[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_CLASS_COUNT:     prdata = APB_DW'(class_count_q);
      REG_FRAME_WIDTH:     prdata = APB_DW'(frame_width_q);
      REG_FRAME_HEIGHT:    prdata = APB_DW'(frame_height_q);
      REG_THRESHOLD_ONE:   prdata = APB_DW'(thresh_q[0]);
      REG_THRESHOLD_TWO:   prdata = APB_DW'(thresh_q[1]);
      REG_THRESHOLD_THREE: prdata = APB_DW'(thresh_q[2]);
      REG_THRESHOLD_FOUR:  prdata = APB_DW'(thresh_q[3]);
      REG_THRESHOLD_FIVE:  prdata = APB_DW'(thresh_q[4]);
      default:             prdata = '0;
    endcase
  end

  // Counts above the lane count act as the lane count plus background.
  logic [CLASS_W-1:0] limit;
  assign limit = (class_count_q < CLASS_W'(MAX_CLASSES)) ? class_count_q
                                                         : CLASS_W'(MAX_CLASSES);

  // ---------------- pipeline control ----------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;

  // ---------------- stage one: lanes and multipliers ----------------
  logic [SCORE_W-1:0] scores [NUM_SCORES];
  lane_t              lanes [NUM_LANES];

  always_comb begin
    scores[0] = score_one_i;
    scores[1] = score_two_i;
    scores[2] = score_three_i;
    scores[3] = score_four_i;
    scores[4] = score_five_i;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    dbd_lane #(
      .LANE_ID (g + 1)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (in_ready_o),
      .limit_i  (limit),
      .score_i  (scores[g]),
      .thresh_i (thresh_q[g]),
      .res_o    (lanes[g])
    );
  end

  logic signed [EDGE_W-1:0] left_d, top_d;
  logic signed [SIZE_W-1:0] width_d, height_d;

  dbd_box_scale u_box (
    .clk_i          (clk_i),
    .en_i           (in_ready_o),
    .x_low_i        (x_low_i),
    .y_low_i        (y_low_i),
    .x_high_i       (x_high_i),
    .y_high_i       (y_high_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .box_left_o     (left_d),
    .box_top_o      (top_d),
    .box_width_o    (width_d),
    .box_height_o   (height_d)
  );

  // ---------------- stage two: merge and output word ----------------
  logic               found;
  logic [CLASS_W-1:0] class_d;
  logic [SCORE_W-1:0] conf_d;

  dbd_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .lanes_i      (lanes),
    .found_o      (found),
    .class_id_o   (class_d),
    .confidence_o (conf_d)
  );

  assign out_valid_d = advance ? (s1_valid_q && found) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  logic [CLASS_W-1:0]       class_q;
  logic [SCORE_W-1:0]       conf_q;
  logic signed [EDGE_W-1:0] left_q, top_q;
  logic signed [SIZE_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      class_q  <= class_d;
      conf_q   <= conf_d;
      left_q   <= left_d;
      top_q    <= top_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign class_id_o   = class_q;
  assign confidence_o = conf_q;
  assign box_left_o   = left_q;
  assign box_top_o    = top_q;
  assign box_width_o  = width_q;
  assign box_height_o = height_q;

  // ---------------- assertions ----------------
  `DBD_ASSERT_NOW(a_class_range, out_valid_o,
    (class_id_o != '0) && (class_id_o <= CLASS_W'(NUM_LANES)),
    "output class outside the lane range")
  `DBD_ASSERT_NEXT(a_drop_unqualified, s1_valid_q && advance && !found,
    !out_valid_o, "box with no qualifying class produced a word")
  `DBD_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o,
    "input stalled with an empty output register")

endmodule
